// ===== sv/ffca_pkg.sv =====
// shared types and constants of the first-fit chunk allocator
`timescale 1ns / 1ps

package ffca_pkg;

	localparam int SIZE_W       = 16;
	localparam int HANDLE_W     = 14;
	localparam int STATUS_W     = 2;
	localparam int HEADER_BYTES = 4;

	// bitmap word of the used map
	localparam int WORD_BITS = 32;
	localparam int WORD_SH   = 5;

	// divider dividend: size + header + rounding fits in 17 bits
	localparam int DIV_W     = SIZE_W + 1;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

	typedef struct packed {
		logic                action;
		logic [SIZE_W-1:0]   alloc_size;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] result_handle;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

// ===== sv/first_fit_chunk_allocator_top.sv =====
// first-fit chunk allocator: used bitmap and run lengths in on-chip memories
//
//   channel | signals                     | direction | transfer
//   --------+-----------------------------+-----------+-----------------------------
//   req     | req_valid req_stall req_data| in        | allocate or free command
//   rsp     | rsp_valid rsp_stall rsp_data| out       | handle and status, one per req
//
// one command at a time: req_stall is low only when the engine is idle
// allocate: divider (reciprocal multiply of size plus header, rounded up), a scan of
//   the bitmap one 32-chunk word at a time (up to CHUNKS/32 words, rounded up),
//   then a read and a write of each bitmap word the run touches
// free: divider with remainder check, one run-length read, then a read and a write
//   of each touched word; after reset a clearing pass zeroes both memories and
//   req is stalled until it ends
// the result register lets a new command enter while the last result waits
`timescale 1ns / 1ps

module first_fit_chunk_allocator_top
	import ffca_pkg::*;
#(
	parameter int CHUNKS      = 1024,
	parameter int CHUNK_BYTES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	// derived sizes
	localparam int NWORDS = (CHUNKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IDX_W  = WA_W + WORD_SH;          // chunk index incl. word padding
	localparam int CA_W   = $clog2(CHUNKS);          // run_length address
	localparam int LEN_W  = $clog2(CHUNKS + 1);      // run length, up to CHUNKS
	localparam int CW     = LEN_W + 6;               // run arithmetic with in-word offsets
	localparam int MW     = CA_W + 8;                // handle product width
	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);

	// divide by CHUNK_BYTES as a multiply by its rounded-up reciprocal,
	// exact for every dividend below 2**DIV_W
	localparam int DIV_S  = DIV_W + $clog2(CHUNK_BYTES);
	localparam int MUL_W  = DIV_W + 1;
	localparam int PROD_W = DIV_W + MUL_W;
	localparam logic [MUL_W-1:0] DIV_M = MUL_W'(((64'd1 << DIV_S) +
		64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DIV   = 8'b0000_0100,
		S_SCAN  = 8'b0000_1000,
		S_FRD   = 8'b0001_0000,
		S_MRD   = 8'b0010_0000,
		S_MWR   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// memories
	logic [WORD_BITS-1:0] used_mem [NWORDS];
	logic [LEN_W-1:0]     run_mem  [CHUNKS];

	logic                 used_we;
	logic [WA_W-1:0]      used_waddr;
	logic [WORD_BITS-1:0] used_wdata;
	logic [WA_W-1:0]      used_raddr;
	logic [WORD_BITS-1:0] used_rd_q;

	logic                 run_we;
	logic [CA_W-1:0]      run_waddr;
	logic [LEN_W-1:0]     run_wdata;
	logic [CA_W-1:0]      run_raddr;
	logic [LEN_W-1:0]     run_rd_q;

	// command registers
	logic                 act_q;
	logic [CA_W-1:0]      clr_q;
	logic [DIV_W-1:0]     div_x_q;
	logic [DIV_W-1:0]     quot_q;
	logic                 div_ph_q;
	logic [LEN_W-1:0]     need_q;
	logic [LEN_W-1:0]     carry_q;
	logic [WA_W-1:0]      cur_q;
	logic [IDX_W-1:0]     lo_q;
	logic [IDX_W-1:0]     hi_q;
	logic [WA_W-1:0]      wcur_q;
	logic                 set_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_data_q;

	// divider
	logic [PROD_W-1:0]    div_prod;
	logic [DIV_W-1:0]     quot_n;
	logic                 rem_nz;

	// scan of one bitmap word
	logic [WORD_BITS-1:0] pad_mask;
	logic [WORD_BITS-1:0] scan_word;
	logic [WORD_BITS-1:0] hit_vec;
	logic                 hit_any;
	logic [WORD_SH-1:0]   hit_pos;
	logic [LEN_W-1:0]     carry_n;
	logic [IDX_W-1:0]     hit_end;
	logic [IDX_W-1:0]     hit_start;

	// run mask within the word being updated
	logic [WORD_BITS-1:0] run_mask;
	logic [IDX_W-1:0]     free_hi;
	logic                 last_wword;
	logic                 rsp_free;

	logic                 req_xfer;
	logic                 rsp_xfer;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_xfer  = rsp_valid_q && !rsp_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// first divider step: quotient by reciprocal multiply
	// second divider step: remainder test against the registered quotient
	assign div_prod = PROD_W'(div_x_q) * PROD_W'(DIV_M);
	assign quot_n   = DIV_W'(div_prod >> DIV_S);
	assign rem_nz   = (div_x_q != DIV_W'(quot_q * DIV_W'(CHUNK_BYTES)));

	// chunks past the end of the pool read as used
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			pad_mask[b] = (32'({cur_q, WORD_SH'(b)}) >= 32'(CHUNKS));
		end
	end

	assign scan_word = used_rd_q | pad_mask;

	// a hit at bit p: the free run ending at p reaches need, either inside
	// the word or together with the free run carried in from lower words
	always_comb begin
		logic [WORD_BITS-1:0] low_m;
		logic [CW-1:0]        need_x;
		logic [CW-1:0]        carry_x;
		logic [CW-1:0]        pp1;
		logic [WORD_SH-1:0]   lo_sh;
		need_x  = CW'(need_q);
		carry_x = CW'(carry_q);
		hit_vec = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			low_m = WORD_BITS'((64'd2 << p) - 64'd1);
			pp1   = CW'(p + 1);
			lo_sh = '0;
			if (need_x <= pp1) begin
				lo_sh      = WORD_SH'(pp1 - need_x);
				hit_vec[p] = (scan_word & low_m & ({WORD_BITS{1'b1}} << lo_sh)) == '0;
			end else begin
				hit_vec[p] = ((scan_word & low_m) == '0) && (carry_x >= need_x - pp1);
			end
		end
	end

	// lowest hit wins
	always_comb begin
		hit_any = 1'b0;
		hit_pos = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (hit_vec[p]) begin
				hit_any = 1'b1;
				hit_pos = WORD_SH'(p);
			end
		end
	end

	// free run reaching into the next word, capped at need
	always_comb begin
		logic [CW-1:0] top_free;
		logic [CW-1:0] run_ext;
		top_free = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (scan_word[b]) begin
				top_free = CW'(WORD_BITS - 1 - b);
			end
		end
		run_ext = (scan_word == '0) ? CW'(carry_q) + CW'(WORD_BITS) : top_free;
		carry_n = (run_ext > CW'(need_q)) ? need_q : LEN_W'(run_ext);
	end

	assign hit_end   = {cur_q, hit_pos};
	assign hit_start = IDX_W'(32'(hit_end) + 32'd1 - 32'(need_q));

	// end of a run being freed, kept inside the pool
	always_comb begin
		if (32'(lo_q) + 32'(run_rd_q) > 32'(CHUNKS)) begin
			free_hi = IDX_W'(CHUNKS - 1);
		end else begin
			free_hi = IDX_W'(32'(lo_q) + 32'(run_rd_q) - 32'd1);
		end
	end

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			run_mask[b] = ({wcur_q, WORD_SH'(b)} >= lo_q) && ({wcur_q, WORD_SH'(b)} <= hi_q);
		end
	end

	assign last_wword = (wcur_q == hi_q[IDX_W-1:WORD_SH]);

	// memory port control
	always_comb begin
		used_we    = 1'b0;
		used_waddr = wcur_q;
		used_wdata = set_q ? (used_rd_q | run_mask) : (used_rd_q & ~run_mask);
		run_we     = 1'b0;
		run_waddr  = lo_q[CA_W-1:0];
		run_wdata  = '0;
		run_raddr  = CA_W'(quot_q);
		case (state_q)
			S_CLEAR: begin
				used_we    = (32'(clr_q) < 32'(NWORDS));
				used_waddr = WA_W'(clr_q);
				used_wdata = '0;
				run_we     = 1'b1;
				run_waddr  = clr_q;
			end
			S_SCAN: begin
				if (hit_any) begin
					run_we    = 1'b1;
					run_waddr = hit_start[CA_W-1:0];
					run_wdata = need_q;
				end
			end
			S_FRD: begin
				run_we = (run_rd_q != '0);
			end
			S_MWR: begin
				used_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_DIV:   used_raddr = '0;
			S_SCAN:  used_raddr = (cur_q == LAST_WORD) ? '0 : cur_q + 1'b1;
			default: used_raddr = wcur_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_waddr] <= used_wdata;
		end
		used_rd_q <= used_mem[used_raddr];
	end

	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[run_waddr] <= run_wdata;
		end
		run_rd_q <= run_mem[run_raddr];
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(CHUNKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_xfer) begin
						if (req_data.action == ACT_FREE &&
							32'(req_data.handle) < 32'(HEADER_BYTES)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_ph_q) begin
						if (act_q == ACT_ALLOC) begin
							state_q <= (32'(quot_q) > 32'(CHUNKS)) ? S_DONE : S_SCAN;
						end else if (rem_nz || 32'(quot_q) >= 32'(CHUNKS)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_FRD;
						end
					end
				end
				S_SCAN: begin
					if (hit_any) begin
						state_q <= S_MRD;
					end else if (cur_q == LAST_WORD) begin
						state_q <= S_DONE;
					end
				end
				S_FRD: begin
					state_q <= (run_rd_q == '0) ? S_DONE : S_MRD;
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					state_q <= last_wword ? S_DONE : S_MRD;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q    <= req_data.action;
				div_ph_q <= 1'b0;
				status_q <= ST_BAD_HANDLE;
				if (req_data.action == ACT_ALLOC) begin
					status_q <= ST_NO_SPACE;
					div_x_q  <= DIV_W'(req_data.alloc_size) +
						DIV_W'(HEADER_BYTES + CHUNK_BYTES - 1);
				end else begin
					div_x_q <= DIV_W'(req_data.handle) - DIV_W'(HEADER_BYTES);
				end
			end
			S_DIV: begin
				div_ph_q <= 1'b1;
				quot_q   <= quot_n;
				need_q   <= LEN_W'(quot_q);
				lo_q     <= IDX_W'(quot_q);
				cur_q    <= '0;
				carry_q  <= '0;
			end
			S_SCAN: begin
				cur_q   <= cur_q + 1'b1;
				carry_q <= carry_n;
				if (hit_any) begin
					lo_q   <= hit_start;
					hi_q   <= hit_end;
					wcur_q <= hit_start[IDX_W-1:WORD_SH];
					set_q  <= 1'b1;
				end
			end
			S_FRD: begin
				hi_q   <= free_hi;
				wcur_q <= lo_q[IDX_W-1:WORD_SH];
				set_q  <= 1'b0;
			end
			S_MWR: begin
				wcur_q <= wcur_q + 1'b1;
				if (last_wword) begin
					status_q <= ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_data_q.status        <= status_q;
			rsp_data_q.result_handle <= '0;
			if (act_q == ACT_ALLOC && status_q == ST_OK) begin
				rsp_data_q.result_handle <= HANDLE_W'(MW'(lo_q[CA_W-1:0]) *
					MW'(CHUNK_BYTES) + MW'(HEADER_BYTES));
			end
		end
	end

endmodule

// ===== sim/first_fit_chunk_allocator_top_tb.sv =====
// self-checking testbench for the first-fit chunk allocator
`timescale 1ns / 1ps

module first_fit_chunk_allocator_top_tb;
	import ffca_pkg::*;

	// geometry the block is built with
	localparam int CHUNKS_TB      = 1024;
	localparam int CHUNK_BYTES_TB = 16;

	// random part and run bounds
	localparam int RAND_ITEMS  = 1250;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 200;
	localparam int CYCLE_LIMIT = 1500000;

	// bookkeeping of the pool plus the queue of outstanding answers
	class alloc_scoreboard;
		bit          used_chunk [CHUNKS_TB];
		int unsigned run_len [CHUNKS_TB];
		int unsigned used_cnt;
		logic [HANDLE_W-1:0] live_q[$];
		rsp_t        answer_q[$];
		int unsigned mismatches;

		function int unsigned pending();
			return answer_q.size();
		endfunction

		function rsp_t predict(req_t r);
			rsp_t        res;
			int unsigned sz, need, run, start, h, pos, len;
			int          idx;
			bit          found;
			res.result_handle = '0;
			found = 1'b0;
			idx = -1;
			if (r.action == ACT_ALLOC) begin
				res.status = ST_NO_SPACE;
				sz = r.alloc_size;
				need = (sz + HEADER_BYTES + CHUNK_BYTES_TB - 1) / CHUNK_BYTES_TB;
				run = 0;
				if (need <= CHUNKS_TB) begin
					for (pos = 0; pos < CHUNKS_TB && !found; pos++) begin
						if (used_chunk[pos]) begin
							run = 0;
						end else begin
							run++;
							if (run == need) begin
								found = 1'b1;
								start = pos + 1 - need;
								for (int k = start; k <= pos; k++)
									used_chunk[k] = 1'b1;
								run_len[start] = need;
								used_cnt += need;
								res.result_handle = HANDLE_W'(start * CHUNK_BYTES_TB + HEADER_BYTES);
								res.status = ST_OK;
								live_q.push_back(res.result_handle);
							end
						end
					end
				end
			end else begin
				res.status = ST_BAD_HANDLE;
				h = r.handle;
				if (h >= HEADER_BYTES && (h - HEADER_BYTES) % CHUNK_BYTES_TB == 0) begin
					start = (h - HEADER_BYTES) / CHUNK_BYTES_TB;
					if (start < CHUNKS_TB && run_len[start] != 0) begin
						len = run_len[start];
						for (pos = start; pos < start + len && pos < CHUNKS_TB; pos++)
							used_chunk[pos] = 1'b0;
						used_cnt -= len;
						run_len[start] = 0;
						res.status = ST_OK;
						foreach (live_q[i])
							if (live_q[i] == r.handle)
								idx = i;
						if (idx >= 0)
							live_q.delete(idx);
					end
				end
			end
			return res;
		endfunction

		function void note_request(req_t r);
			answer_q.push_back(predict(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: handle %0d status %0d",
						got.result_handle, got.status);
				return;
			end
			want = answer_q.pop_front();
			if (got.status !== want.status || got.result_handle !== want.result_handle) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: status exp %0d got %0d, handle exp %0d got %0d",
						want.status, got.status, want.result_handle, got.result_handle);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	alloc_scoreboard sb;
	int  cycle_cnt = 0;
	int  snd_idle = 0;   // percent of cycles the sender sits idle
	int  rcv_idle = 0;   // percent of cycles the receiver stalls
	logic hold_on = 1'b0;
	event hold_ev;

	first_fit_chunk_allocator_top #(
		.CHUNKS      (CHUNKS_TB),
		.CHUNK_BYTES (CHUNK_BYTES_TB)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// watchdog: a hang anywhere ends the run here
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// long receiver hold-off, counted in its own process
	initial begin
		forever begin
			@(hold_ev);
			hold_on <= 1'b1;
			for (int n = 0; n < HOLD_CYCLES; n++)
				@(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// receiver: random stall, forced high during a hold-off
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			rsp_stall <= hold_on || ($urandom_range(99) < rcv_idle);
		end
	end

	// every result transfer is checked against the oldest outstanding answer
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp_data);
	end

	// command with the field it does not use filled with noise
	function automatic req_t make_cmd(logic act, int unsigned val);
		req_t it;
		it.action     = act;
		it.alloc_size = (act == ACT_ALLOC) ? SIZE_W'(val) : SIZE_W'($urandom);
		it.handle     = (act == ACT_FREE) ? HANDLE_W'(val) : HANDLE_W'($urandom);
		return it;
	endfunction

	// random command: mostly frees of live handles and small allocations,
	// free rate rises as the pool fills so it keeps cycling near full
	function automatic req_t rand_cmd();
		int unsigned free_pct, sel, live, sz, h;
		live = sb.live_q.size();
		if (sb.used_cnt > 800)
			free_pct = 70;
		else if (sb.used_cnt > 400)
			free_pct = 50;
		else
			free_pct = 35;
		if (live == 0)
			free_pct = 8;
		if ($urandom_range(99) < free_pct) begin
			sel = $urandom_range(99);
			if (sel < 80 && live > 0)
				h = sb.live_q[$urandom_range(live - 1)];
			else if (sel < 88 && live > 0)
				h = sb.live_q[$urandom_range(live - 1)] + CHUNK_BYTES_TB * $urandom_range(1, 3);
			else if (sel < 94)
				h = CHUNK_BYTES_TB * $urandom_range(CHUNKS_TB - 1) + HEADER_BYTES;
			else
				h = $urandom;
			return make_cmd(ACT_FREE, h);
		end
		sel = $urandom_range(99);
		if (sel < 70)
			sz = $urandom_range(160);
		else if (sel < 90)
			sz = $urandom_range(2000);
		else if (sel < 97)
			sz = $urandom_range(16380);
		else
			sz = $urandom;
		return make_cmd(ACT_ALLOC, sz);
	endfunction

	// one request transfer, with random idle cycles ahead of it
	task automatic send_cmd(input req_t it);
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(it);
	endtask

	// sender pause until every outstanding answer is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: sizes at chunk edges, frees of every bad kind,
		// full pool and its no-space cases
		send_cmd(make_cmd(ACT_ALLOC, 0));        // header alone takes one chunk
		send_cmd(make_cmd(ACT_ALLOC, 12));       // exactly one chunk
		send_cmd(make_cmd(ACT_ALLOC, 13));       // just over one chunk
		send_cmd(make_cmd(ACT_ALLOC, 40));       // three chunks
		send_cmd(make_cmd(ACT_FREE, 84));        // inner chunk of a run
		send_cmd(make_cmd(ACT_FREE, 20));
		send_cmd(make_cmd(ACT_FREE, 20));        // already freed
		send_cmd(make_cmd(ACT_ALLOC, 0));        // reuses the hole
		send_cmd(make_cmd(ACT_FREE, 0));         // below header
		send_cmd(make_cmd(ACT_FREE, 3));
		send_cmd(make_cmd(ACT_FREE, 5));         // misaligned
		send_cmd(make_cmd(ACT_FREE, 16383));     // top handle, misaligned
		send_cmd(make_cmd(ACT_FREE, 16372));     // last chunk, never allocated
		send_cmd(make_cmd(ACT_ALLOC, 65535));    // far larger than the pool
		send_cmd(make_cmd(ACT_ALLOC, 16381));    // one chunk more than the pool
		send_cmd(make_cmd(ACT_ALLOC, 16380));    // whole pool while partly used
		send_cmd(make_cmd(ACT_FREE, 4));
		send_cmd(make_cmd(ACT_FREE, 20));
		send_cmd(make_cmd(ACT_FREE, 36));
		send_cmd(make_cmd(ACT_FREE, 68));
		send_cmd(make_cmd(ACT_ALLOC, 16380));    // whole pool in one run
		send_cmd(make_cmd(ACT_ALLOC, 0));        // pool full
		send_cmd(make_cmd(ACT_FREE, 4));
		send_cmd(make_cmd(ACT_ALLOC, 16364));    // all but the last chunk
		send_cmd(make_cmd(ACT_ALLOC, 0));        // lands in the last chunk

		// random part in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			snd_idle = (ph == 0) ? 24 : (ph == 1) ? 65 : 0;
			rcv_idle = (ph == 0) ? 65 : (ph == 1) ? 24 : 0;
			for (int i = 0; i < RAND_ITEMS / 3; i++) begin
				// receiver holds off while requests keep coming
				if ((ph == 0 && i == 100) || (ph == 2 && i == 20))
					->hold_ev;
				send_cmd(rand_cmd());
			end
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.pending() != 0)
			$display("results missing: %0d", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== first_fit_chunk_allocator_top.f =====
sv/ffca_pkg.sv
sv/first_fit_chunk_allocator_top.sv
sim/first_fit_chunk_allocator_top_tb.sv
